/* hdl/hdll_pkg.sv */
// Shared types and constants for the HID descriptor LED locator.
`default_nettype none
package hdll_pkg;

  typedef enum logic [3:0] {
    ST_OK    = 4'd0,
    ST_LONG  = 4'd1,
    ST_TRUNC = 4'd2,
    ST_SIZE  = 4'd3,
    ST_COUNT = 4'd4,
    ST_UMIN  = 4'd5,
    ST_UMAX  = 4'd6,
    ST_NONE  = 4'd7,
    ST_BIG   = 4'd8
  } status_t;

  // short item tags (prefix with size bits masked off)
  localparam logic [7:0] TAG_USAGE_PAGE = 8'h04;
  localparam logic [7:0] TAG_USAGE_MIN  = 8'h18;
  localparam logic [7:0] TAG_USAGE_MAX  = 8'h28;
  localparam logic [7:0] TAG_REP_SIZE   = 8'h74;
  localparam logic [7:0] TAG_REP_ID     = 8'h84;
  localparam logic [7:0] TAG_REP_COUNT  = 8'h94;
  localparam logic [7:0] TAG_OUTPUT     = 8'h90;
  localparam logic [7:0] TAG_INPUT      = 8'h80;
  localparam logic [7:0] TAG_FEATURE    = 8'hB0;
  localparam logic [7:0] TAG_COLL       = 8'hA0;
  localparam logic [7:0] TAG_END_COLL   = 8'hC0;

  localparam logic [7:0]  LONG_PREFIX   = 8'hFE;
  localparam logic [7:0]  TAG_MASK      = 8'hFC;
  localparam logic [31:0] LED_PAGE      = 32'h8;
  localparam logic [31:0] LED_OUT_DATA  = 32'h2;
  localparam logic [15:0] MAX_BYTES_RST = 16'd1024;

  localparam int OFF_W = 13;

  // parse results handed to the result stage on the last byte
  typedef struct packed {
    status_t            err;
    logic               leds_found;
    logic [31:0]        bit_total;
    logic [7:0]         rid;
    logic [OFF_W-1:0]   bit_off;
  } fin_t;

endpackage
`default_nettype wire

/* hdl/hdll_in_if.sv */
// Descriptor byte channel.
`default_nettype none
interface hdll_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] desc_byte;
  logic       is_last;

  modport source (output valid, desc_byte, is_last, input ready);
  modport sink   (input valid, desc_byte, is_last, output ready);
endinterface
`default_nettype wire

/* hdl/hdll_out_if.sv */
// Result channel.
`default_nettype none
interface hdll_out_if;
  logic                  valid;
  logic                  ready;
  hdll_pkg::status_t     status;
  logic [7:0]            led_rid;
  logic [12:0]           led0_bit;
  logic [12:0]           led1_bit;
  logic [12:0]           led2_bit;
  logic [15:0]           output_bytes;

  modport source (output valid, status, led_rid, led0_bit, led1_bit,
                  led2_bit, output_bytes, input ready);
  modport sink   (input valid, status, led_rid, led0_bit, led1_bit,
                  led2_bit, output_bytes, output ready);
endinterface
`default_nettype wire

/* hdl/hdll_cfg_if.sv */
// Configuration write channel (max output bytes).
`default_nettype none
interface hdll_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

/* hdl/hdll_parse.sv */
// Input register and short item parser with descriptor tracking state.
`default_nettype none
module hdll_parse (
  input  wire logic          clk,
  input  wire logic          rst_n,
  hdll_in_if.sink            in_ch,
  output logic               fin_valid,
  input  wire logic          fin_ready,
  output hdll_pkg::fin_t     fin_o
);
  import hdll_pkg::*;

  logic        in_v_r;
  logic [7:0]  byte_r;
  logic        last_r;
  logic        fire;

  logic [2:0]        bytes_left_r, bytes_left_nxt;
  logic [1:0]        byte_idx_r, byte_idx_nxt;
  logic [7:0]        tag_r, tag_nxt;
  logic [31:0]       value_r, value_nxt;
  logic [31:0]       size_r, size_nxt;
  logic [31:0]       count_r, count_nxt;
  logic [31:0]       umin_r, umin_nxt;
  logic [31:0]       umax_r, umax_nxt;
  logic [7:0]        rid_r, rid_nxt;
  logic              led_page_r, led_page_nxt;
  logic              found_r, found_nxt;
  logic [7:0]        srid_r, srid_nxt;
  logic [OFF_W-1:0]  soff_r, soff_nxt;
  logic [31:0]       total_r, total_nxt;
  status_t           err_r, err_nxt;

  logic        run;
  logic [7:0]  run_tag;
  logic [31:0] run_data;
  logic [31:0] merged;
  logic [63:0] prod;
  logic [31:0] prod_sat;
  logic [32:0] sum;
  logic [31:0] total_add;

  assign fire        = in_v_r && (!last_r || fin_ready);
  assign in_ch.ready = !in_v_r || fire;
  assign fin_valid   = in_v_r && last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.desc_byte;
      last_r <= in_ch.is_last;
    end
  end

  // size * count, saturated, added to the running total with saturation
  assign prod      = {32'd0, size_r} * {32'd0, count_r};
  assign prod_sat  = (|prod[63:32]) ? 32'hFFFF_FFFF : prod[31:0];
  assign sum       = {1'b0, prod_sat} + {1'b0, total_r};
  assign total_add = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign merged    = value_r | ({24'd0, byte_r} << {byte_idx_r, 3'b000});

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    byte_idx_nxt   = byte_idx_r;
    tag_nxt        = tag_r;
    value_nxt      = value_r;
    size_nxt       = size_r;
    count_nxt      = count_r;
    umin_nxt       = umin_r;
    umax_nxt       = umax_r;
    rid_nxt        = rid_r;
    led_page_nxt   = led_page_r;
    found_nxt      = found_r;
    srid_nxt       = srid_r;
    soff_nxt       = soff_r;
    total_nxt      = total_r;
    err_nxt        = err_r;
    run            = 1'b0;
    run_tag        = byte_r & TAG_MASK;
    run_data       = 32'd0;

    if (err_r == ST_OK) begin
      if (bytes_left_r == 3'd0) begin
        if (byte_r == LONG_PREFIX) begin
          err_nxt = ST_LONG;
        end else if (byte_r[1:0] == 2'd0) begin
          run = 1'b1;
        end else if (last_r) begin
          err_nxt = ST_TRUNC;
        end else begin
          tag_nxt        = byte_r & TAG_MASK;
          value_nxt      = 32'd0;
          byte_idx_nxt   = 2'd0;
          bytes_left_nxt = (byte_r[1:0] == 2'd3) ? 3'd4 : {1'b0, byte_r[1:0]};
        end
      end else begin
        value_nxt      = merged;
        byte_idx_nxt   = byte_idx_r + 2'd1;
        bytes_left_nxt = bytes_left_r - 3'd1;
        if (bytes_left_r == 3'd1) begin
          run      = 1'b1;
          run_tag  = tag_r;
          run_data = merged;
        end else if (last_r) begin
          err_nxt = ST_TRUNC;
        end
      end
    end

    if (run) begin
      unique case (run_tag) inside
        TAG_USAGE_PAGE: led_page_nxt = (run_data == LED_PAGE);
        TAG_USAGE_MIN:  umin_nxt     = run_data;
        TAG_USAGE_MAX:  umax_nxt     = run_data;
        TAG_REP_SIZE:   size_nxt     = run_data;
        TAG_REP_ID:     rid_nxt      = run_data[7:0];
        TAG_REP_COUNT:  count_nxt    = run_data;
        TAG_OUTPUT: begin
          if (led_page_r && run_data == LED_OUT_DATA && size_r != 32'd1) begin
            err_nxt = ST_SIZE;
          end else if (led_page_r && run_data == LED_OUT_DATA && count_r != 32'd3) begin
            err_nxt = ST_COUNT;
          end else if (led_page_r && run_data == LED_OUT_DATA && umin_r != 32'd1) begin
            err_nxt = ST_UMIN;
          end else if (led_page_r && run_data == LED_OUT_DATA && umax_r != 32'd3) begin
            err_nxt = ST_UMAX;
          end else begin
            if (led_page_r && run_data == LED_OUT_DATA) begin
              found_nxt = 1'b1;
              srid_nxt  = rid_r;
              soff_nxt  = total_r[OFF_W-1:0];
            end
            total_nxt = total_add;
            umin_nxt  = 32'd0;
            umax_nxt  = 32'd0;
          end
        end
        TAG_INPUT, TAG_FEATURE, TAG_COLL, TAG_END_COLL: begin
          umin_nxt = 32'd0;
          umax_nxt = 32'd0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    fin_o.err        = err_nxt;
    fin_o.leds_found = found_nxt;
    fin_o.bit_total  = total_nxt;
    fin_o.rid        = srid_nxt;
    fin_o.bit_off    = soff_nxt;
  end

  // the last byte of a descriptor returns all parse state to reset
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last_r)) begin
      bytes_left_r <= 3'd0;
      byte_idx_r   <= 2'd0;
      tag_r        <= 8'd0;
      value_r      <= 32'd0;
      size_r       <= 32'd0;
      count_r      <= 32'd0;
      umin_r       <= 32'd0;
      umax_r       <= 32'd0;
      rid_r        <= 8'd0;
      led_page_r   <= 1'b0;
      found_r      <= 1'b0;
      srid_r       <= 8'd0;
      soff_r       <= '0;
      total_r      <= 32'd0;
      err_r        <= ST_OK;
    end else if (fire) begin
      bytes_left_r <= bytes_left_nxt;
      byte_idx_r   <= byte_idx_nxt;
      tag_r        <= tag_nxt;
      value_r      <= value_nxt;
      size_r       <= size_nxt;
      count_r      <= count_nxt;
      umin_r       <= umin_nxt;
      umax_r       <= umax_nxt;
      rid_r        <= rid_nxt;
      led_page_r   <= led_page_nxt;
      found_r      <= found_nxt;
      srid_r       <= srid_nxt;
      soff_r       <= soff_nxt;
      total_r      <= total_nxt;
      err_r        <= err_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/hdll_result.sv */
// Snapshot register and result register: final status, LED offsets, length.
`default_nettype none
module hdll_result (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fin_valid,
  output logic               fin_ready,
  input  hdll_pkg::fin_t     fin_i,
  input  wire logic [15:0]   max_bytes,
  hdll_out_if.source         out_ch
);
  import hdll_pkg::*;

  logic              snap_v_r;
  fin_t              snap_r;
  logic              snap_fire;

  logic              out_v_r;
  status_t           status_r, status_nxt;
  logic [7:0]        rid_r;
  logic [OFF_W-1:0]  led0_r, led1_r, led2_r;
  logic [15:0]       bytes_r;

  logic [32:0]       bits_up;
  logic [29:0]       nbytes;
  logic              ok;

  assign snap_fire = snap_v_r && (!out_v_r || out_ch.ready);
  assign fin_ready = !snap_v_r || snap_fire;

  assign bits_up = {1'b0, snap_r.bit_total} + 33'd7;
  assign nbytes  = bits_up[32:3];

  always_comb begin
    if (snap_r.err != ST_OK) begin
      status_nxt = snap_r.err;
    end else if (!snap_r.leds_found) begin
      status_nxt = ST_NONE;
    end else if (nbytes > {14'd0, max_bytes}) begin
      status_nxt = ST_BIG;
    end else begin
      status_nxt = ST_OK;
    end
  end
  assign ok = (status_nxt == ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (fin_ready) begin
        snap_v_r <= fin_valid;
      end
      if (!out_v_r || out_ch.ready) begin
        out_v_r <= snap_v_r;
      end
    end
    if (fin_ready && fin_valid) begin
      snap_r <= fin_i;
    end
    if (snap_fire) begin
      status_r <= status_nxt;
      rid_r    <= ok ? snap_r.rid : 8'd0;
      led0_r   <= ok ? snap_r.bit_off : '0;
      led1_r   <= ok ? snap_r.bit_off + OFF_W'(1) : '0;
      led2_r   <= ok ? snap_r.bit_off + OFF_W'(2) : '0;
      bytes_r  <= ok ? nbytes[15:0] : 16'd0;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.status       = status_r;
  assign out_ch.led_rid      = rid_r;
  assign out_ch.led0_bit     = led0_r;
  assign out_ch.led1_bit     = led1_r;
  assign out_ch.led2_bit     = led2_r;
  assign out_ch.output_bytes = bytes_r;

endmodule
`default_nettype wire

/* hdl/hid_descriptor_led_locator_core.sv */
// Top level of the HID descriptor LED locator.
// Throughput: one descriptor byte per cycle; with two results waiting and out_ch not ready, the next last byte stalls.
// A result reaches out_ch from its last byte through the input register, the parse into the
//   snapshot register and the status into the result register.
// Reset (rst_n low, synchronous): parse state cleared, channels empty,
//   max output bytes back to 1024.
`default_nettype none
module hid_descriptor_led_locator_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hdll_in_if.sink     in_ch,
  hdll_out_if.source  out_ch,
  hdll_cfg_if.sink    cfg_ch
);
  import hdll_pkg::*;

  logic [15:0] max_bytes_r;
  logic        fin_valid;
  logic        fin_ready;
  fin_t        fin;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= MAX_BYTES_RST;
    end else if (cfg_ch.valid) begin
      max_bytes_r <= cfg_ch.data;
    end
  end

  hdll_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin_o     (fin)
  );

  hdll_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin_i     (fin),
    .max_bytes (max_bytes_r),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
